// ----- rtl/core/pfx_eval_pkg.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Widths, token codes, error codes and controller states shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_eval_pkg;

    // Stack geometry and arithmetic word width
    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    // Stream payload layout
    localparam int TOKEN_W     = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int ERROR_W     = 2;
    localparam int M_TDATA_W   = ((OUT_VALUE_W + ERROR_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - OUT_VALUE_W - ERROR_W;

    // Token codes
    localparam logic [TOKEN_W-1:0] TOK_ADD  = 8'h2B;
    localparam logic [TOKEN_W-1:0] TOK_SUB  = 8'h2D;
    localparam logic [TOKEN_W-1:0] TOK_MUL  = 8'h2A;
    localparam logic [TOKEN_W-1:0] TOK_DIV  = 8'h2F;
    localparam logic [TOKEN_W-1:0] TOK_ZERO = 8'h30;

    // Error codes
    typedef enum logic [ERROR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIVZERO   = 2'd3
    } err_t;

    // Controller states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_DIVWB = 6'b001000,
        ST_FINRD = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/postfix_expression_evaluator_core.sv -----
// Postfix evaluator: tokens enter on the s_ stream one beat at a time and the
// operand stack lives in a synchronous memory with two read ports. An operand
// token is a write at the stack pointer. For a +, - or * token the two pops
// are read in the accept cycle and the result is computed and written back
// in the next. A / token runs the radix-2 restoring divider, one quotient bit
// per cycle, and is written back from ST_DIVWB; a divide by zero skips the
// divider. The beat marked tlast adds a final pop (read in ST_FINRD, then load
// of the result register in ST_FIN); the result waits in an output register,
// so new tokens are taken while it is unclaimed, and only a further final
// result stalls until it is taken.
// ----------------------------------------------------------------------------
// Postfix expression evaluator core
// Stack-based evaluation of character tokens with sticky error reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Token stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pfx_eval_pkg::TOKEN_W-1:0]    s_tdata,   // [7:0] token
    input  wire logic                                s_tlast,
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [pfx_eval_pkg::M_TDATA_W-1:0]       m_tdata    // [31:0] value, [33:32] error
);

    localparam int W  = pfx_eval_pkg::VALUE_WIDTH;
    localparam int PW = pfx_eval_pkg::PTR_W;
    localparam int AW = pfx_eval_pkg::ADDR_W;
    localparam int CW = pfx_eval_pkg::CNT_W;

    // Stack memory and read data
    logic [W-1:0]  stack_mem [pfx_eval_pkg::STACK_DEPTH];
    logic [W-1:0]  rd0_reg;
    logic [W-1:0]  rd1_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;

    // Control state
    pfx_eval_pkg::state_t state_reg, state_next;
    logic [PW-1:0]        sp_reg, sp_next;
    pfx_eval_pkg::err_t   sticky_reg, sticky_next;
    logic [pfx_eval_pkg::TOKEN_W-1:0] tok_reg;
    logic                 last_reg;

    // Divider registers
    logic [W-1:0]  dquo_reg, dquo_next;
    logic [W-1:0]  drem_reg, drem_next;
    logic [W-1:0]  ddiv_reg;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic          dneg_reg;
    logic          div_start;

    // Output register
    logic                                  m_valid_reg, m_valid_next;
    logic [pfx_eval_pkg::OUT_VALUE_W-1:0]  m_value_reg;
    logic [pfx_eval_pkg::ERROR_W-1:0]      m_error_reg;
    logic                                  out_load;
    logic [W-1:0]                          fin_value;
    pfx_eval_pkg::err_t                    fin_error;

    // Datapath helpers
    logic          s_accept;
    logic          tok_is_op;
    logic          full;
    logic [W-1:0]  right_val;
    logic [W-1:0]  left_val;
    logic          under;
    logic [PW-1:0] sp_popped;
    logic [W-1:0]  alu_res;
    logic          div_zero;
    logic [W-1:0]  abs_left;
    logic [W-1:0]  abs_right;
    logic [W:0]    trial;
    logic [W-1:0]  div_q;

    assign s_tready  = (state_reg == pfx_eval_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign tok_is_op = (s_tdata == pfx_eval_pkg::TOK_ADD) || (s_tdata == pfx_eval_pkg::TOK_SUB)
                    || (s_tdata == pfx_eval_pkg::TOK_MUL) || (s_tdata == pfx_eval_pkg::TOK_DIV);
    assign full      = (sp_reg == PW'(pfx_eval_pkg::STACK_DEPTH));

    // Read the top two entries on an operator beat and in the final read
    assign rd_en    = (s_accept && tok_is_op) || (state_reg == pfx_eval_pkg::ST_FINRD);
    assign rd_addr0 = AW'(sp_reg - PW'(1));
    assign rd_addr1 = AW'(sp_reg - PW'(2));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd0_reg <= stack_mem[rd_addr0];
            rd1_reg <= stack_mem[rd_addr1];
        end
    end

    // Pop results with underflow substitution
    assign right_val = (sp_reg >= PW'(1)) ? rd0_reg : '1;
    assign left_val  = (sp_reg >= PW'(2)) ? rd1_reg : '1;
    assign under     = (sp_reg < PW'(2));
    assign sp_popped = under ? '0 : sp_reg - PW'(2);
    assign div_zero  = (right_val == '0);
    assign abs_left  = left_val[W-1]  ? W'(-left_val)  : left_val;
    assign abs_right = right_val[W-1] ? W'(-right_val) : right_val;

    // Add, subtract, multiply
    always_comb begin
        case (tok_reg)
            pfx_eval_pkg::TOK_ADD: alu_res = W'(left_val + right_val);
            pfx_eval_pkg::TOK_SUB: alu_res = W'(left_val - right_val);
            pfx_eval_pkg::TOK_MUL: alu_res = W'(left_val * right_val);
            default:               alu_res = '0;
        endcase
    end

    // Restoring division step
    assign trial = {drem_reg, dquo_reg[W-1]} - {1'b0, ddiv_reg};
    always_comb begin
        if (!trial[W]) begin
            drem_next = trial[W-1:0];
            dquo_next = {dquo_reg[W-2:0], 1'b1};
        end else begin
            drem_next = {drem_reg[W-2:0], dquo_reg[W-1]};
            dquo_next = {dquo_reg[W-2:0], 1'b0};
        end
        dcnt_next = dcnt_reg - CW'(1);
    end
    assign div_q = dneg_reg ? W'(-dquo_reg) : dquo_reg;

    // Final pop
    assign fin_value = (sp_reg >= PW'(1)) ? rd0_reg : '1;
    always_comb begin
        if (sticky_reg != pfx_eval_pkg::ERR_NONE) begin
            fin_error = sticky_reg;
        end else if (sp_reg == '0) begin
            fin_error = pfx_eval_pkg::ERR_UNDERFLOW;
        end else begin
            fin_error = pfx_eval_pkg::ERR_NONE;
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        sticky_next  = sticky_reg;
        mem_we       = 1'b0;
        mem_waddr    = AW'(sp_reg);
        mem_wdata    = W'(s_tdata) - W'(pfx_eval_pkg::TOK_ZERO);
        div_start    = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            pfx_eval_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (tok_is_op) begin
                        state_next = pfx_eval_pkg::ST_EXEC;
                    end else begin
                        if (full) begin
                            if (sticky_reg == pfx_eval_pkg::ERR_NONE) begin
                                sticky_next = pfx_eval_pkg::ERR_OVERFLOW;
                            end
                        end else begin
                            mem_we  = 1'b1;
                            sp_next = sp_reg + PW'(1);
                        end
                        if (s_tlast) begin
                            state_next = pfx_eval_pkg::ST_FINRD;
                        end
                    end
                end
            end
            pfx_eval_pkg::ST_EXEC: begin
                if (sticky_reg == pfx_eval_pkg::ERR_NONE) begin
                    if (under) begin
                        sticky_next = pfx_eval_pkg::ERR_UNDERFLOW;
                    end else if (tok_reg == pfx_eval_pkg::TOK_DIV && div_zero) begin
                        sticky_next = pfx_eval_pkg::ERR_DIVZERO;
                    end
                end
                if (tok_reg == pfx_eval_pkg::TOK_DIV && !div_zero) begin
                    div_start  = 1'b1;
                    sp_next    = sp_popped;
                    state_next = pfx_eval_pkg::ST_DIV;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(sp_popped);
                    mem_wdata  = alu_res;
                    sp_next    = sp_popped + PW'(1);
                    state_next = last_reg ? pfx_eval_pkg::ST_FINRD : pfx_eval_pkg::ST_IDLE;
                end
            end
            pfx_eval_pkg::ST_DIV: begin
                if (dcnt_reg == '0) begin
                    state_next = pfx_eval_pkg::ST_DIVWB;
                end
            end
            pfx_eval_pkg::ST_DIVWB: begin
                mem_we     = 1'b1;
                mem_wdata  = div_q;
                sp_next    = sp_reg + PW'(1);
                state_next = last_reg ? pfx_eval_pkg::ST_FINRD : pfx_eval_pkg::ST_IDLE;
            end
            pfx_eval_pkg::ST_FINRD: begin
                state_next = pfx_eval_pkg::ST_FIN;
            end
            pfx_eval_pkg::ST_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    sp_next      = '0;
                    sticky_next  = pfx_eval_pkg::ERR_NONE;
                    state_next   = pfx_eval_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfx_eval_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfx_eval_pkg::ST_IDLE;
            sp_reg      <= '0;
            sticky_reg  <= pfx_eval_pkg::ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: token, divider, result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tok_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        if (div_start) begin
            dquo_reg <= abs_left;
            drem_reg <= '0;
            ddiv_reg <= abs_right;
            dcnt_reg <= CW'(W - 1);
            dneg_reg <= left_val[W-1] ^ right_val[W-1];
        end else if (state_reg == pfx_eval_pkg::ST_DIV) begin
            dquo_reg <= dquo_next;
            drem_reg <= drem_next;
            dcnt_reg <= dcnt_next;
        end
        if (out_load) begin
            m_value_reg <= pfx_eval_pkg::OUT_VALUE_W'(signed'(fin_value));
            m_error_reg <= fin_error;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {pfx_eval_pkg::M_PAD_W'(0), m_error_reg, m_value_reg};

endmodule

`default_nettype wire

// ----- dv/pfx_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Postfix evaluator result checker
// Watches the token and result streams, keeps its own model of the operand
// stack and sticky error, and compares each result beat with the oldest
// predicted result.
// ----------------------------------------------------------------------------

module pfx_result_checker
    import pfx_eval_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TOKEN_W-1:0]     s_tdata,    // [7:0] token
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,    // [31:0] value, [33:32] error
    output int                     mismatch_count,
    output int                     pending_results,
    output int                     results_checked
);

    localparam int MAX_REPORTS = 20;

    typedef struct {
        logic [OUT_VALUE_W-1:0] value;
        err_t                   error;
    } result_t;

    // Model of the operand stack
    logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
    int                     stack_level;
    err_t                   sticky_err;
    result_t                expected_results [$];

    // Keep only the first error since the last result
    function automatic void note_error(input err_t code);
        if (sticky_err == ERR_NONE) begin
            sticky_err = code;
        end
    endfunction

    // Drop the push when the stack is full
    function automatic void push_value(input logic [VALUE_WIDTH-1:0] v);
        if (stack_level >= STACK_DEPTH) begin
            note_error(ERR_OVERFLOW);
        end else begin
            stack_mem[stack_level] = v;
            stack_level++;
        end
    endfunction

    // Popping an empty stack yields all ones and leaves it empty
    function automatic logic [VALUE_WIDTH-1:0] pop_value();
        if (stack_level == 0) begin
            note_error(ERR_UNDERFLOW);
            return '1;
        end
        stack_level--;
        return stack_mem[stack_level];
    endfunction

    // Truncating signed divide on magnitudes, so the most negative value
    // divided by minus one wraps instead of trapping
    function automatic logic [VALUE_WIDTH-1:0] quotient(input logic [VALUE_WIDTH-1:0] num,
                                                        input logic [VALUE_WIDTH-1:0] den);
        logic [VALUE_WIDTH-1:0] mag_num, mag_den, q;
        mag_num = num[VALUE_WIDTH-1] ? -num : num;
        mag_den = den[VALUE_WIDTH-1] ? -den : den;
        if (mag_den == '0) begin
            note_error(ERR_DIVZERO);
            return '0;
        end
        q = mag_num / mag_den;
        if (num[VALUE_WIDTH-1] != den[VALUE_WIDTH-1]) begin
            q = -q;
        end
        return q;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result check failed: %s", $time, what);
        end
    endtask

    always @(posedge aclk) begin : sample
        logic [VALUE_WIDTH-1:0] rhs, lhs, res;
        logic [OUT_VALUE_W-1:0] got_value;
        err_t                   got_error;
        result_t                want;
        if (!aresetn) begin
            stack_level = 0;
            sticky_err  = ERR_NONE;
            expected_results.delete();
        end else begin
            // Compare a result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_value = m_tdata[OUT_VALUE_W-1:0];
                got_error = err_t'(m_tdata[OUT_VALUE_W +: ERROR_W]);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat value=%0d error=%0d with none pending",
                                              $signed(got_value), got_error));
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got_value !== want.value) begin
                        report_mismatch($sformatf("value %0d, predicted %0d",
                                                  $signed(got_value), $signed(want.value)));
                    end
                    if (got_error !== want.error) begin
                        report_mismatch($sformatf("error %0d, predicted %s",
                                                  got_error, want.error.name()));
                    end
                end
            end

            // Advance the stack model by one token beat
            if (s_tvalid && s_tready) begin
                case (s_tdata)
                    TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV: begin
                        rhs = pop_value();
                        lhs = pop_value();
                        case (s_tdata)
                            TOK_ADD: res = lhs + rhs;
                            TOK_SUB: res = lhs - rhs;
                            TOK_MUL: res = lhs * rhs;
                            default: res = quotient(lhs, rhs);
                        endcase
                        push_value(res);
                    end
                    default: begin
                        push_value(VALUE_WIDTH'(int'(s_tdata) - int'(TOK_ZERO)));
                    end
                endcase

                // Final pop on the last token, then clear the expression
                if (s_tlast) begin
                    res        = pop_value();
                    want.value = OUT_VALUE_W'($signed(res));
                    want.error = sticky_err;
                    expected_results.push_back(want);
                    stack_level = 0;
                    sticky_err  = ERR_NONE;
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

// ----- dv/postfix_expression_evaluator_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Postfix evaluator core testbench
// Drives directed and random token streams into the core under several
// sender and receiver idle profiles; the result checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------

module postfix_expression_evaluator_core_test;
    import pfx_eval_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 64;      // long enough for a divide plus the final pop
    localparam int PHASE_TOKENS = 100;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [TOKEN_W-1:0]   s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycle_count    = 0;
    int tokens_sent    = 0;
    int exprs_sent     = 0;
    int phase_tokens   = 0;

    logic [TOKEN_W-1:0] expr_tokens [$];

    postfix_expression_evaluator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pfx_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall the result stream at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results pending",
                     cycle_count, pending_results);
            $display("postfix_expression_evaluator_core: mismatch");
            $finish;
        end
    end

    // Token that pushes the given value
    function automatic logic [TOKEN_W-1:0] operand_token(input int value);
        return TOKEN_W'(int'(TOK_ZERO) + value);
    endfunction

    // Mostly decimal digits, sometimes any non-operator byte
    function automatic logic [TOKEN_W-1:0] random_operand();
        logic [TOKEN_W-1:0] tok;
        if ($urandom_range(0, 99) < 85) begin
            return operand_token($urandom_range(0, 9));
        end
        do begin
            tok = TOKEN_W'($urandom);
        end while (tok inside {TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV});
        return tok;
    endfunction

    function automatic logic [TOKEN_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return TOK_ADD;
            1:       return TOK_SUB;
            2:       return TOK_MUL;
            default: return TOK_DIV;
        endcase
    endfunction

    // Idle at random, then hold one beat until it is taken
    task automatic send_beat(input logic [TOKEN_W-1:0] tok, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= TOKEN_W'($urandom);
            s_tlast  <= 1'($urandom_range(0, 1));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tok;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tokens_sent++;
        phase_tokens++;
    endtask

    // Send the queued tokens, marking the final one
    task automatic send_expression();
        for (int i = 0; i < expr_tokens.size(); i++) begin
            send_beat(expr_tokens[i], i == expr_tokens.size() - 1);
        end
        exprs_sent++;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target, depth, push_pct, noise_len;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        phase_tokens   = 0;
        while (phase_tokens < PHASE_TOKENS) begin
            if ($urandom_range(0, 99) < 10) begin
                // Broken stream: raw bytes, last at random
                noise_len = $urandom_range(1, 6);
                repeat (noise_len) begin
                    send_beat(TOKEN_W'($urandom), $urandom_range(0, 99) < 30);
                end
            end else begin
                // Well-formed expression; the deep ones can run past the stack depth
                if ($urandom_range(0, 99) < 12) begin
                    target   = $urandom_range(16, 22);
                    push_pct = 90;
                end else begin
                    target   = $urandom_range(1, 11);
                    push_pct = 55;
                end
                depth = 0;
                expr_tokens.delete();
                while (expr_tokens.size() < target || depth != 1) begin
                    if (depth < 2 || (expr_tokens.size() < target &&
                                      $urandom_range(0, 99) < push_pct)) begin
                        expr_tokens.push_back(random_operand());
                        depth++;
                    end else begin
                        expr_tokens.push_back(random_operator());
                        depth--;
                    end
                end
                send_expression();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // All four operators: (9 - 3) * 4 / 2
        expr_tokens = '{operand_token(9), operand_token(3), TOK_SUB, operand_token(4),
                        TOK_MUL, operand_token(2), TOK_DIV};
        send_expression();
        // Operator on an empty stack underflows both pops
        expr_tokens = '{TOK_ADD};
        send_expression();
        // Lowest and highest token bytes, then a divide by zero
        expr_tokens = '{operand_token(-48), operand_token(207), TOK_MUL,
                        operand_token(0), TOK_DIV};
        send_expression();
        // Build the most negative value (128^4 * 8) and divide it by minus one
        expr_tokens = '{operand_token(128), operand_token(128), TOK_MUL,
                        operand_token(128), TOK_MUL, operand_token(128), TOK_MUL,
                        operand_token(8), TOK_MUL, operand_token(0), operand_token(1),
                        TOK_SUB, TOK_DIV};
        send_expression();

        run_phase(0, 0);
        run_phase(62, 0);
        run_phase(0, 62);
        run_phase(23, 23);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d tokens in %0d well-formed expressions plus noise bursts,",
                 tokens_sent, exprs_sent);
        $display("under four idle/stall profiles; %0d results compared, %0d failures.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("postfix_expression_evaluator_core: match");
        end else begin
            $display("postfix_expression_evaluator_core: mismatch");
        end
        $finish;
    end

endmodule
